FILE: rtl/tll_pkg.sv
package tll_pkg;

    // Index datapath width (low bits of each incoming index are kept)
    localparam int INDEX_WIDTH = 32;
    // Width of the index fields on the channels
    localparam int LINE_W      = 32;
    // Indices held by one job
    localparam int JOB_SLOTS   = 6;
    // Buffered indices of one quad group before its sixth arrives
    localparam int GROUP_DEPTH = 5;

    typedef logic [INDEX_WIDTH-1:0] idx_t;
    typedef logic [2:0]             fill_t;
    typedef logic [3:0]             step_t;
    typedef logic [2:0]             slot_t;

    // What the back end emits for one job
    typedef enum logic [1:0] {
        JOB_TRI     = 2'd0,   // p0,p1,p1,p2,p2,p0
        JOB_QUAD    = 2'd1,   // a,b,b,c,c,e,e,a
        JOB_TWO_TRI = 2'd2    // two triangles from six indices
    } job_kind_t;

    typedef struct packed {
        job_kind_t                 kind;
        logic [JOB_SLOTS-1:0][INDEX_WIDTH-1:0] idx;
    } job_t;

    localparam slot_t TRI_SLOTS [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam slot_t QUAD_SLOTS [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam slot_t TWO_TRI_SLOTS [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0, 3'd3, 3'd4,
        3'd4, 3'd5, 3'd5, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0
    };

    // Which job slot feeds output number step
    function automatic slot_t slot_sel(job_kind_t kind, step_t step);
        slot_t s;
        s = '0;
        unique case (kind)
            JOB_TRI:     s = TRI_SLOTS[step];
            JOB_QUAD:    s = QUAD_SLOTS[step];
            JOB_TWO_TRI: s = TWO_TRI_SLOTS[step];
            default:     s = '0;
        endcase
        return s;
    endfunction

    // Step number of the final output of a job
    function automatic step_t last_step(job_kind_t kind);
        step_t l;
        l = '0;
        unique case (kind)
            JOB_TRI:     l = 4'd5;
            JOB_QUAD:    l = 4'd7;
            JOB_TWO_TRI: l = 4'd11;
            default:     l = '0;
        endcase
        return l;
    endfunction

endpackage

FILE: rtl/tll_if.sv
// Triangle-list index channel
interface tll_in_if;
    import tll_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [LINE_W-1:0]    index_value;
    logic                 end_of_list;

    modport source (output valid, output index_value, output end_of_list, input ready);
    modport sink   (input valid, input index_value, input end_of_list, output ready);
endinterface

// Line-list index channel
interface tll_out_if;
    import tll_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [LINE_W-1:0]    line_index;
    logic                 run_last;

    modport source (output valid, output line_index, output run_last, input ready);
    modport sink   (input valid, input line_index, input run_last, output ready);
endinterface

FILE: rtl/tll_front.sv
// Accepts indices, groups them and decides quad or triangle jobs
module tll_front (
    input  logic           clk,
    input  logic           rst_n,
    tll_in_if.sink         tri_in,
    input  logic           queue_full,
    output logic           push,
    output tll_pkg::job_t  push_job
);
    import tll_pkg::*;

    idx_t  buf_reg [GROUP_DEPTH];
    fill_t fill_reg, fill_next;
    logic  tri_mode_reg, tri_mode_next;
    logic  first_reg, first_next;

    logic  fire;
    idx_t  v;
    logic  last;
    logic  quad_ok;
    logic  buf_we;
    fill_t buf_wa;

    assign tri_in.ready = !queue_full;
    assign fire = tri_in.valid && tri_in.ready;
    assign v    = tri_in.index_value[INDEX_WIDTH-1:0];
    assign last = tri_in.end_of_list;

    // grid quad test; wraps at INDEX_WIDTH bits
    assign quad_ok = (buf_reg[1] == idx_t'(buf_reg[0] + 1'b1)) &&
                     (buf_reg[3] == buf_reg[2]) &&
                     (buf_reg[4] == idx_t'(buf_reg[3] - 1'b1)) &&
                     (v == buf_reg[0]) && !(last && first_reg);

    // classification and job build
    always_comb
    begin
        fill_next     = fill_reg;
        tri_mode_next = tri_mode_reg;
        first_next    = first_reg;
        push          = 1'b0;
        buf_we        = 1'b0;
        buf_wa        = fill_reg;
        push_job.kind = JOB_TRI;
        push_job.idx  = {buf_reg[0], v, buf_reg[4], buf_reg[3], buf_reg[1], buf_reg[0]};
        if (fire)
        begin
            priority if (tri_mode_reg)
            begin
                if (fill_reg == 3'd2)
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_TRI;
                    push_job.idx  = {buf_reg[0], buf_reg[0], buf_reg[0],
                                     v, buf_reg[1], buf_reg[0]};
                    fill_next     = '0;
                end
                else
                begin
                    buf_we    = 1'b1;
                    buf_wa    = {2'b00, fill_reg[0]};
                    fill_next = fill_reg + 3'd1;
                end
            end
            else if (fill_reg >= 3'(GROUP_DEPTH))
            begin
                push          = 1'b1;
                push_job.kind = quad_ok ? JOB_QUAD : JOB_TWO_TRI;
                push_job.idx  = {v, buf_reg[4], buf_reg[3],
                                 buf_reg[2], buf_reg[1], buf_reg[0]};
                if (!quad_ok)
                    tri_mode_next = 1'b1;
                first_next    = 1'b0;
                fill_next     = '0;
            end
            else
            begin
                buf_we    = 1'b1;
                fill_next = fill_reg + 3'd1;
                // partial group at end of list gives its first triangle
                if (last && fill_reg >= 3'd2)
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_TRI;
                    push_job.idx  = {buf_reg[0], buf_reg[0], buf_reg[0],
                                     (fill_reg == 3'd2) ? v : buf_reg[2],
                                     buf_reg[1], buf_reg[0]};
                end
            end
            if (last)
            begin
                fill_next     = '0;
                tri_mode_next = 1'b0;
                first_next    = 1'b1;
            end
        end
    end

    // group buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            unique case (buf_wa)
                3'd0:    buf_reg[0] <= v;
                3'd1:    buf_reg[1] <= v;
                3'd2:    buf_reg[2] <= v;
                3'd3:    buf_reg[3] <= v;
                3'd4:    buf_reg[4] <= v;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            tri_mode_reg <= 1'b0;
            first_reg    <= 1'b1;
        end
        else
        begin
            fill_reg     <= fill_next;
            tri_mode_reg <= tri_mode_next;
            first_reg    <= first_next;
        end
    end

endmodule

FILE: rtl/tll_queue.sv
// Two-entry job queue between front and back
module tll_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tll_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tll_pkg::job_t  head
);
    import tll_pkg::*;

    job_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = ent_reg[rd_ptr_reg];

    // pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/tll_back.sv
// Walks the queued job, one line index per cycle into the output register while the output is not stalled
module tll_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tll_pkg::job_t  head,
    output logic           pop,
    tll_out_if.source      line_out
);
    import tll_pkg::*;

    step_t            step_reg, step_next;
    logic             ov_reg, ov_next;
    logic [LINE_W-1:0] idx_reg, idx_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_end;

    assign load   = !empty && (!ov_reg || line_out.ready);
    assign at_end = (step_reg == last_step(head.kind));
    assign pop    = load && at_end;

    assign line_out.valid      = ov_reg;
    assign line_out.line_index = idx_reg;
    assign line_out.run_last   = last_reg;

    // next output and step
    always_comb
    begin
        step_next = step_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        ov_next   = ov_reg && !line_out.ready;
        if (load)
        begin
            ov_next   = 1'b1;
            idx_next  = LINE_W'(head.idx[slot_sel(head.kind, step_reg)]);
            last_next = at_end;
            step_next = at_end ? '0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

FILE: rtl/triangle_list_to_line_list.sv
// Channel    Dir  Payload                       Accepted when
// tri_in     in   index_value[31:0], end_of_list  valid && ready
// line_out   out  line_index[31:0], run_last      valid && ready
//
// The front takes one index per cycle while the two-entry job queue has room;
// indices that complete nothing only update the group state.
// The back emits one line index per cycle from the queue head while the output is
// not stalled: 6, 8 or 12 per job, so a triangle stream gives two per input index.
// Reset (rst_n low, async) returns to quad mode with an empty group and queue.
// A stalled output holds its register; the queue then fills and stalls input.
module triangle_list_to_line_list (
    input  logic       clk,
    input  logic       rst_n,
    tll_in_if.sink     tri_in,
    tll_out_if.source  line_out
);
    import tll_pkg::*;

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic empty;
    job_t head;

    tll_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_in     (tri_in),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    tll_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    tll_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .line_out (line_out)
    );

endmodule

FILE: bench/triangle_list_to_line_list_tb.sv
module triangle_list_to_line_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tll_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int TARGET_REQS = 360;
    localparam int MAX_PRINTS = 50;

    typedef struct {
        logic [LINE_W-1:0] index_value;
        logic              end_of_list;
    } tri_req_t;

    typedef struct {
        logic [LINE_W-1:0] line_index;
        logic              run_last;
    } line_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    tll_in_if  tri_in_bus ();
    tll_out_if line_out_bus ();

    triangle_list_to_line_list DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .tri_in   (tri_in_bus),
        .line_out (line_out_bus)
    );

    // Requests waiting to be offered, and line indices waiting to come out
    tri_req_t  tri_req_q [$];
    line_exp_t line_exp_q [$];

    // List under construction
    idx_t list_q [$];

    // Shadow of the converter state
    idx_t  grp_buf [GROUP_DEPTH];
    fill_t grp_fill  = '0;
    logic  tri_mode  = 1'b0;
    logic  first_grp = 1'b1;

    // Line indices caused by the request being converted
    idx_t line_seq [12];
    int   line_cnt;

    int   err_count = 0;
    int   res_count = 0;
    int   in_gap    = 0;
    int   out_gap   = 0;
    int   hold_left = 0;
    int   hold_clk  = 0;
    logic hold_off  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Random index, biased toward the wrap points
    function automatic idx_t rand_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return idx_t'(1) << (INDEX_WIDTH - 1);
            3:       return ~(idx_t'(1) << (INDEX_WIDTH - 1));
            default: return idx_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [LINE_W-1:0] got,
                                   logic [LINE_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns result %0d: %s got %h want %h",
                     $time, res_count, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Line-list prediction
    // ---------------------------------------------------------------
    task automatic put_line(idx_t v);
        line_seq[line_cnt] = v;
        line_cnt++;
    endtask

    task automatic put_tri(idx_t p0, idx_t p1, idx_t p2);
        put_line(p0);
        put_line(p1);
        put_line(p1);
        put_line(p2);
        put_line(p2);
        put_line(p0);
    endtask

    task automatic convert_index(logic [LINE_W-1:0] raw, logic eol);
        idx_t      v;
        idx_t      a, b, c, d, e, f;
        logic      is_quad;
        line_exp_t item;
        v = raw[INDEX_WIDTH-1:0];
        line_cnt = 0;
        if (tri_mode)
        begin
            // triangle mode: every third index closes a triangle
            if (grp_fill == 3'd2)
            begin
                put_tri(grp_buf[0], grp_buf[1], v);
                grp_fill = '0;
            end
            else
            begin
                grp_buf[grp_fill[0]] = v;
                grp_fill++;
            end
        end
        else if (grp_fill >= 3'(GROUP_DEPTH))
        begin
            // sixth index of a quad group: decide quad or two triangles
            a = grp_buf[0];
            b = grp_buf[1];
            c = grp_buf[2];
            d = grp_buf[3];
            e = grp_buf[4];
            f = v;
            is_quad = (b == idx_t'(a + 1'b1)) && (d == c) &&
                      (e == idx_t'(d - 1'b1)) && (f == a);
            // a list of exactly six is always two triangles
            if (eol && first_grp)
                is_quad = 1'b0;
            if (is_quad)
            begin
                put_line(a);
                put_line(b);
                put_line(b);
                put_line(c);
                put_line(c);
                put_line(e);
                put_line(e);
                put_line(a);
            end
            else
            begin
                put_tri(a, b, c);
                put_tri(d, e, f);
                tri_mode = 1'b1;
            end
            first_grp = 1'b0;
            grp_fill = '0;
        end
        else
        begin
            grp_buf[grp_fill] = v;
            grp_fill++;
            // partial quad group at the end gives one triangle
            if (eol && grp_fill >= 3'd3)
                put_tri(grp_buf[0], grp_buf[1], grp_buf[2]);
        end
        for (int k = 0; k < line_cnt; k++)
        begin
            item.line_index = LINE_W'(line_seq[k]);
            item.run_last   = (k == line_cnt - 1);
            line_exp_q = {line_exp_q, item};
        end
        if (eol)
        begin
            grp_fill  = '0;
            tri_mode  = 1'b0;
            first_grp = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // List building
    // ---------------------------------------------------------------
    task automatic list_add(idx_t v);
        list_q = {list_q, v};
    endtask

    task automatic add_quad(idx_t a, idx_t c);
        list_add(a);
        list_add(idx_t'(a + 1'b1));
        list_add(c);
        list_add(c);
        list_add(idx_t'(c - 1'b1));
        list_add(a);
    endtask

    // Quad group with one of b, d, e, f off by a single bit
    task automatic add_near_quad(idx_t a, idx_t c);
        idx_t g [6];
        int   pos;
        g[0] = a;
        g[1] = idx_t'(a + 1'b1);
        g[2] = c;
        g[3] = c;
        g[4] = idx_t'(c - 1'b1);
        g[5] = a;
        case ($urandom_range(0, 3))
            0:       pos = 1;
            1:       pos = 3;
            2:       pos = 4;
            default: pos = 5;
        endcase
        g[pos] = g[pos] ^ (idx_t'(1) << $urandom_range(0, INDEX_WIDTH - 1));
        for (int k = 0; k < 6; k++)
            list_add(g[k]);
    endtask

    task automatic add_random(int n);
        repeat (n)
            list_add(rand_index());
    endtask

    // Move the list into the request queue, marking its final index
    task automatic close_list();
        tri_req_t req;
        for (int k = 0; k < list_q.size(); k++)
        begin
            req.index_value = LINE_W'(list_q[k]);
            req.end_of_list = (k == list_q.size() - 1);
            tri_req_q = {tri_req_q, req};
        end
        list_q.delete();
    endtask

    task automatic gen_random_list();
        int nq;
        int tail;
        int n;
        nq   = $urandom_range(0, 5);
        tail = $urandom_range(0, 3);
        if (tail == 3)
        begin
            // noise list
            add_random($urandom_range(1, 16));
        end
        else
        begin
            repeat (nq)
                add_quad(rand_index(), rand_index());
            if (tail == 0)
            begin
                // ends in quad mode with 0..5 leftovers
                n = $urandom_range((nq == 0) ? 1 : 0, 5);
                add_random(n);
            end
            else
            begin
                // breaks into triangle mode
                add_near_quad(rand_index(), rand_index());
                n = $urandom_range(0, 6);
                add_random(3 * n);
                add_random($urandom_range(0, 2));
            end
        end
        close_list();
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        logic next_valid;
        if (rst_n)
        begin
            next_valid = tri_in_bus.valid;
            if (tri_in_bus.valid && tri_in_bus.ready)
            begin
                convert_index(tri_in_bus.index_value, tri_in_bus.end_of_list);
                void'(tri_req_q.pop_front());
                in_gap = gap_len();
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (tri_req_q.size() != 0)
                begin
                    next_valid = 1'b1;
                    tri_in_bus.index_value <= tri_req_q[0].index_value;
                    tri_in_bus.end_of_list <= tri_req_q[0].end_of_list;
                end
            end
            tri_in_bus.valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : collect_proc
        line_exp_t want;
        if (rst_n)
        begin
            if (line_out_bus.valid && line_out_bus.ready)
            begin
                res_count++;
                if (line_exp_q.size() == 0)
                    report_mismatch("unexpected line_index", line_out_bus.line_index, '0);
                else
                begin
                    want = line_exp_q.pop_front();
                    if (line_out_bus.line_index !== want.line_index)
                        report_mismatch("line_index", line_out_bus.line_index,
                                        want.line_index);
                    if (line_out_bus.run_last !== want.run_last)
                        report_mismatch("run_last", LINE_W'(line_out_bus.run_last),
                                        LINE_W'(want.run_last));
                end
                out_gap = gap_len();
            end
            if (out_gap > 0)
                out_gap--;
            line_out_bus.ready <= !hold_off && (out_gap == 0);
        end
    end

    // Long receiver hold-off so the job queue fills and back-pressures input
    always @(posedge clk)
    begin : hold_proc
        if (rst_n)
        begin
            hold_clk++;
            if (hold_clk == 300 || hold_clk == 1200)
                hold_left = HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left--;
            hold_off <= (hold_left > 0);
        end
    end

    // Progress watchdog: cycles with no request accepted on either side
    initial
    begin : watchdog_proc
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (tri_in_bus.valid && tri_in_bus.ready) ||
                (line_out_bus.valid && line_out_bus.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin : run_proc
        rst_n = 1'b0;
        tri_in_bus.valid       = 1'b0;
        tri_in_bus.index_value = '0;
        tri_in_bus.end_of_list = 1'b0;
        line_out_bus.ready     = 1'b0;

        // exactly six, quad-shaped: still two triangles
        add_quad('0, '1);
        close_list();

        // quad wrapping at both ends, then a three-index partial group
        add_quad('1, '0);
        list_add(idx_t'(1) << (INDEX_WIDTH - 1));
        list_add(~(idx_t'(1) << (INDEX_WIDTH - 1)));
        list_add(rand_index());
        close_list();

        // failing group, one triangle, one leftover dropped
        add_near_quad(idx_t'(16), idx_t'(40));
        add_random(3);
        add_random(1);
        close_list();

        // single index list: nothing comes out
        list_add('1);
        close_list();

        while (tri_req_q.size() < TARGET_REQS)
            gen_random_list();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (tri_req_q.size() != 0)
            @(posedge clk);
        while (line_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/tll_pkg.sv
rtl/tll_if.sv
rtl/tll_front.sv
rtl/tll_queue.sv
rtl/tll_back.sv
rtl/triangle_list_to_line_list.sv
bench/triangle_list_to_line_list_tb.sv
